/* rtl/fsg_pkg.sv */
// Package for the falling sand grid block: sizes, cell codes, command codes, payload types.
// No dependencies.
package fsg_pkg;
	localparam int GRID_ROWS = 64;
	localparam int GRID_COLS = 64;
	localparam int ROW_W = $clog2(GRID_ROWS);
	localparam int COL_W = $clog2(GRID_COLS);
	localparam int ADDR_W = ROW_W + COL_W;
	localparam int CELL_COUNT = GRID_ROWS * GRID_COLS;
	localparam int CELL_W = 3;

	localparam logic [1:0] T_EMPTY = 2'd0;
	localparam logic [1:0] T_SAND  = 2'd1;
	localparam logic [1:0] T_WATER = 2'd2;
	localparam logic [1:0] T_SOLID = 2'd3;

	localparam logic [2:0] CMD_SPAWN  = 3'd0;
	localparam logic [2:0] CMD_REMOVE = 3'd1;
	localparam logic [2:0] CMD_PASS   = 3'd2;
	localparam logic [2:0] CMD_READ   = 3'd3;
	localparam logic [2:0] CMD_CLEAR  = 3'd4;

	typedef struct packed {
		logic [2:0] cmd;
		logic [5:0] cell_row;
		logic [5:0] cell_col;
		logic [1:0] particle_type;
	} cmd_t;

	typedef struct packed {
		logic [1:0] cell_type;
		logic       accepted;
	} rsp_t;

	function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] r,
	                                                 logic [COL_W-1:0] c);
		return {r, c};
	endfunction
endpackage

/* rtl/fsg_if.sv */
// Valid/ready channel interface carrying one payload type.
// Depends on fsg_pkg.
interface fsg_cmd_if import fsg_pkg::*; ();
	logic valid;
	logic ready;
	cmd_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/fsg_rsp_if.sv */
// Valid/ready channel interface for result beats.
// Depends on fsg_pkg.
interface fsg_rsp_if import fsg_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/falling_sand_grid_step.sv */
// Falling sand grid: command sequencer around one grid RAM port.
// Depends on fsg_pkg, fsg_cmd_if, fsg_rsp_if, fsg_ram.
//
//  channel | dir | payload
//  cmd_in  | in  | cmd, cell_row, cell_col, particle_type
//  rsp_out | out | cell_type, accepted
//
// Spawn/remove/read do one RAM read, then an optional write; clear writes every cell to empty.
// A pass visits every cell, with up to 8 RAM accesses per cell (here, five
// candidates, two writes), then runs a mark-clear sweep that reads and
// rewrites each cell; all accesses are serialised on the single RAM port.
// After reset a clearing sweep writes every cell; no command is taken.
// A result stays in the output register until taken; ready is low meanwhile.
module falling_sand_grid_step import fsg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	fsg_cmd_if.sink   cmd_in,
	fsg_rsp_if.source rsp_out
);
	localparam logic [3:0] S_INIT  = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_ONE   = 4'd2;  // single-cell read wait
	localparam logic [3:0] S_ONE2  = 4'd3;
	localparam logic [3:0] S_CLR   = 4'd4;
	localparam logic [3:0] S_HRD   = 4'd5;  // read here
	localparam logic [3:0] S_HWT   = 4'd6;
	localparam logic [3:0] S_CRD   = 4'd7;  // read candidate
	localparam logic [3:0] S_CWT   = 4'd8;
	localparam logic [3:0] S_CEV   = 4'd9;
	localparam logic [3:0] S_WR1   = 4'd10; // write dest / mark here
	localparam logic [3:0] S_WR2   = 4'd11; // write here (swap)
	localparam logic [3:0] S_NEXT  = 4'd12;
	localparam logic [3:0] S_SWEEP = 4'd13; // clear marks
	localparam logic [3:0] S_SWT   = 4'd14;
	localparam logic [3:0] S_RSP   = 4'd15;

	logic [3:0] state_q;
	cmd_t cmd_q;
	logic [ADDR_W:0] cnt_q;
	logic [ROW_W-1:0] r_q;
	logic [COL_W-1:0] c_q;
	logic [2:0] cand_q;      // 0 down,1 down-left,2 down-right,3 left,4 right
	logic [CELL_W-1:0] here_q, dst_q;
	logic [ADDR_W-1:0] dadr_q;
	rsp_t rsp_q;

	logic we;
	logic [ADDR_W-1:0] addr;
	logic [CELL_W-1:0] wdata, rdata;

	fsg_ram #(.WIDTH(CELL_W), .DEPTH(CELL_COUNT)) u_grid (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	logic in_grid;
	assign in_grid = (32'(cmd_q.cell_row) < GRID_ROWS) && (32'(cmd_q.cell_col) < GRID_COLS);

	// candidate coordinates
	logic cvalid;
	logic [ROW_W-1:0] cr;
	logic [COL_W-1:0] cc;
	logic last_c, last_r;
	assign last_c = (32'(c_q) == GRID_COLS - 1);
	assign last_r = (32'(r_q) == GRID_ROWS - 1);
	always_comb begin
		cr = r_q;
		cc = c_q + COL_W'(1);
		cvalid = 1'b0;
		unique case (cand_q)
			3'd0: cvalid = !last_c;
			3'd1: begin cr = r_q - ROW_W'(1); cvalid = !last_c && r_q != '0; end
			3'd2: begin cr = r_q + ROW_W'(1); cvalid = !last_c && !last_r; end
			3'd3: begin cr = r_q - ROW_W'(1); cc = c_q; cvalid = r_q != '0; end
			3'd4: begin cr = r_q + ROW_W'(1); cc = c_q; cvalid = !last_r; end
			default: cvalid = 1'b0;
		endcase
	end

	logic is_sand, can;
	assign is_sand = here_q[1:0] == T_SAND;
	assign can = (cand_q < 3'd3) ?
		(rdata[1:0] == T_EMPTY || (is_sand && rdata[1:0] == T_WATER)) :
		(rdata[1:0] == T_EMPTY);

	always_comb begin
		we = 1'b0;
		addr = cell_addr(ROW_W'(cmd_q.cell_row), COL_W'(cmd_q.cell_col));
		wdata = '0;
		unique case (state_q)
			S_INIT, S_CLR: begin
				we = 1'b1; addr = cnt_q[ADDR_W-1:0];
			end
			S_ONE2: begin
				we = in_grid && ((cmd_q.cmd == CMD_SPAWN && rdata[1:0] == T_EMPTY)
					|| cmd_q.cmd == CMD_REMOVE);
				wdata = (cmd_q.cmd == CMD_SPAWN) ? {1'b0, cmd_q.particle_type} : '0;
			end
			S_HRD: addr = cell_addr(r_q, c_q);
			// hold the candidate address so the read data survives the wait
			S_CRD, S_CWT: addr = cell_addr(cr, cc);
			S_WR1: begin
				we = 1'b1; addr = dadr_q; wdata = {1'b1, here_q[1:0]};
			end
			S_WR2: begin
				we = 1'b1; addr = cell_addr(r_q, c_q); wdata = dst_q;
			end
			S_SWEEP: addr = cnt_q[ADDR_W-1:0];
			S_SWT: begin
				we = 1'b1; addr = cnt_q[ADDR_W-1:0]; wdata = {1'b0, rdata[1:0]};
			end
			default: ;
		endcase
	end

	assign cmd_in.ready = state_q == S_IDLE;
	assign rsp_out.valid = state_q == S_RSP;
	assign rsp_out.data = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_INIT, S_CLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (32'(cnt_q) == CELL_COUNT - 1) begin
						rsp_q.accepted <= 1'b1;
						state_q <= (state_q == S_INIT) ? S_IDLE : S_RSP;
					end
				end
				S_IDLE: if (cmd_in.valid) begin
					cmd_q <= cmd_in.data;
					cnt_q <= '0;
					r_q <= ROW_W'(GRID_ROWS - 1);
					c_q <= COL_W'(GRID_COLS - 1);
					rsp_q <= '0;
					priority case (cmd_in.data.cmd)
						CMD_PASS: state_q <= S_HRD;
						CMD_CLEAR: state_q <= S_CLR;
						CMD_SPAWN, CMD_REMOVE, CMD_READ: state_q <= S_ONE;
						default: state_q <= S_RSP;
					endcase
				end
				S_ONE: state_q <= S_ONE2;
				S_ONE2: begin
					rsp_q.accepted <= in_grid && (cmd_q.cmd != CMD_SPAWN
						|| rdata[1:0] == T_EMPTY);
					rsp_q.cell_type <= (in_grid && cmd_q.cmd == CMD_READ) ? rdata[1:0] : T_EMPTY;
					state_q <= S_RSP;
				end
				S_HRD: state_q <= S_HWT;
				S_HWT: begin
					here_q <= rdata;
					cand_q <= '0;
					if (rdata[1:0] == T_EMPTY || rdata[2]) begin
						state_q <= S_NEXT;
					end else if (rdata[1:0] == T_SOLID) begin
						dadr_q <= cell_addr(r_q, c_q);
						state_q <= S_WR1;
					end else begin
						state_q <= S_CRD;
					end
				end
				S_CRD: begin
					dadr_q <= cell_addr(cr, cc);
					state_q <= cvalid ? S_CWT : S_CEV;
				end
				S_CWT: state_q <= S_CEV;
				S_CEV: begin
					dst_q <= rdata;
					if (cvalid && can) begin
						state_q <= S_WR1;
					end else if (cand_q == 3'd4 || (cand_q == 3'd2 && is_sand)) begin
						dadr_q <= cell_addr(r_q, c_q);
						state_q <= S_WR1;
					end else begin
						cand_q <= cand_q + 3'd1;
						state_q <= S_CRD;
					end
				end
				S_WR1: state_q <= (dadr_q == cell_addr(r_q, c_q)) ? S_NEXT : S_WR2;
				S_WR2: state_q <= S_NEXT;
				S_NEXT: begin
					c_q <= c_q - COL_W'(1);
					if (c_q == '0) begin
						c_q <= COL_W'(GRID_COLS - 1);
						r_q <= r_q - ROW_W'(1);
						if (r_q == '0) begin
							state_q <= S_SWEEP;
						end else begin
							state_q <= S_HRD;
						end
					end else begin
						state_q <= S_HRD;
					end
				end
				S_SWEEP: state_q <= S_SWT;
				S_SWT: begin
					cnt_q <= cnt_q + 1'b1;
					if (32'(cnt_q) == CELL_COUNT - 1) begin
						rsp_q.accepted <= 1'b1;
						state_q <= S_RSP;
					end else begin
						state_q <= S_SWEEP;
					end
				end
				S_RSP: if (rsp_out.ready) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd_in.ready && rsp_out.valid)) else $error("ready while result pending");
	a_rsp_after: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_out.valid && !rsp_out.ready |=> rsp_out.valid && $stable(rsp_out.data))
		else $error("result dropped");
	a_celltype: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_out.valid && cmd_q.cmd != CMD_READ |-> rsp_out.data.cell_type == T_EMPTY)
		else $error("cell_type on non-read");
endmodule

/* rtl/fsg_ram.sv */
// Generic single port RAM with registered read.
// No dependencies.
module fsg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
